[design/rlgb_pkg.sv]
`default_nettype none

package rlgb_pkg;

  // store depth, a power of two
  localparam int STORE_TEXELS = 4096;
  localparam int ADDR_W = $clog2(STORE_TEXELS);
  localparam int CNT_W = 13;
  localparam int CFG_W = 16;
  localparam int SUM_W = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_CODE  = 2'd3;

  localparam logic [2:0] REG_COLOR_RED   = 3'd0;
  localparam logic [2:0] REG_COLOR_GREEN = 3'd1;
  localparam logic [2:0] REG_COLOR_BLUE  = 3'd2;
  localparam logic [2:0] REG_MAP_WIDTH   = 3'd3;
  localparam logic [2:0] REG_RECT_LEFT   = 3'd4;
  localparam logic [2:0] REG_RECT_TOP    = 3'd5;
  localparam logic [2:0] REG_RECT_WIDTH  = 3'd6;
  localparam logic [2:0] REG_RECT_HEIGHT = 3'd7;

  localparam logic [7:0] ESCAPE_CODE = 8'hFF;

  localparam logic [1:0] PHASE_PLAIN = 2'd0;
  localparam logic [1:0] PHASE_COUNT = 2'd1;
  localparam logic [1:0] PHASE_VALUE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] texel_address;
    logic [7:0]  write_red;
    logic [7:0]  write_green;
    logic [7:0]  write_blue;
    logic [7:0]  code_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic       rect_done;
  } out_t;

  typedef struct packed {
    logic              load;
    logic              advance;
    logic [ADDR_W-1:0] origin;
  } cur_ctrl_t;

  typedef struct packed {
    logic              rows_zero;
    logic [ADDR_W-1:0] addr;
  } cur_stat_t;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [11:0] a);
    logic [ADDR_W+11:0] w;
    w = {{ADDR_W{1'b0}}, a};
    return w[ADDR_W-1:0];
  endfunction

  function automatic logic [7:0] chan_add(input logic [15:0] color, input logic [7:0] v);
    logic [23:0] p;
    p = {8'd0, color} * {16'd0, v};
    return (p[23:20] != 4'd0) ? 8'hFF : p[19:12];
  endfunction

  function automatic logic [7:0] sat8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

`default_nettype wire

[design/rlgb_cursor.sv]
`default_nettype none

module rlgb_cursor (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire rlgb_pkg::cur_ctrl_t     ctrl,
  input  wire [rlgb_pkg::CNT_W-1:0]    map_width,
  input  wire [rlgb_pkg::CNT_W-1:0]    rect_width,
  input  wire [rlgb_pkg::CNT_W-1:0]    rect_height,
  output rlgb_pkg::cur_stat_t          stat
);

  logic [rlgb_pkg::ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [rlgb_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic [rlgb_pkg::CNT_W-1:0]  cols_r, cols_nxt;
  logic [rlgb_pkg::CNT_W-1:0]  rows_r, rows_nxt;
  logic [rlgb_pkg::CNT_W-1:0]  cols_dec, rows_dec;
  logic [rlgb_pkg::SUM_W-1:0]  base_sum;

  assign base_sum = rlgb_pkg::SUM_W'(base_r) + rlgb_pkg::SUM_W'(map_width);

  always_comb begin
    cursor_nxt = cursor_r;
    base_nxt   = base_r;
    cols_nxt   = cols_r;
    rows_nxt   = rows_r;
    cols_dec   = (cols_r != '0) ? cols_r - rlgb_pkg::CNT_W'(1) : '0;
    rows_dec   = (rows_r != '0) ? rows_r - rlgb_pkg::CNT_W'(1) : '0;
    if (rows_dec != '0 && rect_width == '0) begin
      rows_dec = '0;
    end
    if (ctrl.load) begin
      cursor_nxt = ctrl.origin;
      base_nxt   = ctrl.origin;
      if (rect_width == '0 || rect_height == '0) begin
        cols_nxt = '0;
        rows_nxt = '0;
      end else begin
        cols_nxt = rect_width;
        rows_nxt = rect_height;
      end
    end else if (ctrl.advance) begin
      if (cols_dec == '0) begin
        rows_nxt = rows_dec;
        cols_nxt = '0;
        if (rows_dec != '0) begin
          base_nxt   = base_sum[rlgb_pkg::ADDR_W-1:0];
          cursor_nxt = base_sum[rlgb_pkg::ADDR_W-1:0];
          cols_nxt   = rect_width;
        end
      end else begin
        cols_nxt   = cols_dec;
        cursor_nxt = cursor_r + rlgb_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      base_r   <= '0;
      cols_r   <= '0;
      rows_r   <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      base_r   <= base_nxt;
      cols_r   <= cols_nxt;
      rows_r   <= rows_nxt;
    end
  end

  assign stat.rows_zero = (rows_r == '0);
  assign stat.addr      = cursor_r;

endmodule

`default_nettype wire

[design/rle_light_group_blender_top.sv]
`default_nettype none

// RGB lightmap store with a run-length light blender.
// Input channel: in_data is taken at a clock edge with start high and busy low.
// Kinds: texel write, texel read, start of a rectangle, code byte of the light stream.
// cfg_we/index/data write one register per edge; user writes only while idle, unchecked.
// Result channel: one word per input word, shown for a single cycle with out_valid high.
// The receiver cannot stall; a result must be taken in the cycle it is shown.
// Steps from acceptance to result strobe:
//   texel write, escape byte, run count byte or ignored byte: next cycle, busy stays low
//   texel read: registered store read, then the result
//   rectangle start: origin multiply, then cursor load
//   value byte: a read state and a write state per lit texel, up to run + 1 texels; one
//   more read state when the run is cut off at the end of the rectangle
// Each lit texel is one read-modify-write of the single store: a read state (ST_LREAD)
// and then a write state (ST_LWRITE).
// Reset (rst_n low, synchronous) restores register defaults, idles the rectangle
// (rect_done reads 1) and clears the decoder; store contents stay undefined until written.

module rle_light_group_blender_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire rlgb_pkg::in_t           in_data,
  output logic                         out_valid,
  output rlgb_pkg::out_t               out_data,
  input  wire                          cfg_we,
  input  wire [2:0]                    cfg_index,
  input  wire [rlgb_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_ORIGIN = 3'd2;
  localparam logic [2:0] ST_LREAD  = 3'd3;
  localparam logic [2:0] ST_LWRITE = 3'd4;

  logic [15:0]                  color_red_r, color_green_r, color_blue_r;
  logic [rlgb_pkg::CNT_W-1:0]   map_width_r, rect_width_r, rect_height_r;
  logic [11:0]                  rect_left_r, rect_top_r;

  logic [2:0]                   state_r, state_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [7:0]                   pending_r, pending_nxt;
  logic [7:0]                   run_r, run_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   out_red_r, out_red_nxt;
  logic [7:0]                   out_green_r, out_green_nxt;
  logic [7:0]                   out_blue_r, out_blue_nxt;
  logic [7:0]                   add_red_r, add_green_r, add_blue_r;
  logic [rlgb_pkg::ADDR_W-1:0]  prod_r;
  logic [24:0]                  prod_full;

  logic [23:0]                  mem [rlgb_pkg::STORE_TEXELS];
  logic [23:0]                  rdata_r;
  logic                         mem_we;
  logic [rlgb_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [23:0]                  mem_wdata;

  logic                         accept;
  rlgb_pkg::cur_ctrl_t          cur_ctrl;
  rlgb_pkg::cur_stat_t          cur_stat;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign prod_full = {13'd0, rect_top_r} * {12'd0, map_width_r};
  assign mem_raddr = (state_r == ST_IDLE) ? rlgb_pkg::to_addr(in_data.texel_address)
                                          : cur_stat.addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_red_r   <= 16'd4096;
      color_green_r <= 16'd4096;
      color_blue_r  <= 16'd4096;
      map_width_r   <= 13'd64;
      rect_left_r   <= '0;
      rect_top_r    <= '0;
      rect_width_r  <= 13'd1;
      rect_height_r <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        rlgb_pkg::REG_COLOR_RED:   color_red_r   <= cfg_data;
        rlgb_pkg::REG_COLOR_GREEN: color_green_r <= cfg_data;
        rlgb_pkg::REG_COLOR_BLUE:  color_blue_r  <= cfg_data;
        rlgb_pkg::REG_MAP_WIDTH:   map_width_r   <= cfg_data[rlgb_pkg::CNT_W-1:0];
        rlgb_pkg::REG_RECT_LEFT:   rect_left_r   <= cfg_data[11:0];
        rlgb_pkg::REG_RECT_TOP:    rect_top_r    <= cfg_data[11:0];
        rlgb_pkg::REG_RECT_WIDTH:  rect_width_r  <= cfg_data[rlgb_pkg::CNT_W-1:0];
        rlgb_pkg::REG_RECT_HEIGHT: rect_height_r <= cfg_data[rlgb_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pending_nxt   = pending_r;
    run_nxt       = run_r;
    out_valid_nxt = 1'b0;
    out_red_nxt   = 8'd0;
    out_green_nxt = 8'd0;
    out_blue_nxt  = 8'd0;
    mem_we        = 1'b0;
    mem_waddr     = cur_stat.addr;
    mem_wdata     = {rlgb_pkg::sat8(rdata_r[23:16], add_red_r),
                     rlgb_pkg::sat8(rdata_r[15:8], add_green_r),
                     rlgb_pkg::sat8(rdata_r[7:0], add_blue_r)};
    cur_ctrl      = '0;
    cur_ctrl.origin = prod_r + rlgb_pkg::to_addr(rect_left_r);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_data.kind)
            rlgb_pkg::KIND_WRITE: begin
              mem_we        = 1'b1;
              mem_waddr     = rlgb_pkg::to_addr(in_data.texel_address);
              mem_wdata     = {in_data.write_red, in_data.write_green, in_data.write_blue};
              out_valid_nxt = 1'b1;
            end
            rlgb_pkg::KIND_READ: begin
              state_nxt = ST_READ;
            end
            rlgb_pkg::KIND_START: begin
              state_nxt = ST_ORIGIN;
            end
            default: begin
              if (cur_stat.rows_zero) begin
                out_valid_nxt = 1'b1;
              end else if (phase_r == rlgb_pkg::PHASE_COUNT) begin
                pending_nxt   = in_data.code_byte;
                phase_nxt     = rlgb_pkg::PHASE_VALUE;
                out_valid_nxt = 1'b1;
              end else if (phase_r == rlgb_pkg::PHASE_PLAIN &&
                           in_data.code_byte == rlgb_pkg::ESCAPE_CODE) begin
                phase_nxt     = rlgb_pkg::PHASE_COUNT;
                out_valid_nxt = 1'b1;
              end else begin
                run_nxt     = (phase_r == rlgb_pkg::PHASE_VALUE) ? pending_r : 8'd0;
                pending_nxt = 8'd0;
                phase_nxt   = rlgb_pkg::PHASE_PLAIN;
                state_nxt   = ST_LREAD;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        out_red_nxt   = rdata_r[23:16];
        out_green_nxt = rdata_r[15:8];
        out_blue_nxt  = rdata_r[7:0];
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_ORIGIN: begin
        cur_ctrl.load = 1'b1;
        phase_nxt     = rlgb_pkg::PHASE_PLAIN;
        pending_nxt   = 8'd0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_LREAD: begin
        if (cur_stat.rows_zero) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_LWRITE;
        end
      end
      ST_LWRITE: begin
        mem_we           = 1'b1;
        cur_ctrl.advance = 1'b1;
        if (run_r == 8'd0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          run_nxt   = run_r - 8'd1;
          state_nxt = ST_LREAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= rlgb_pkg::PHASE_PLAIN;
      pending_r   <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    if (accept) begin
      add_red_r   <= rlgb_pkg::chan_add(color_red_r, in_data.code_byte);
      add_green_r <= rlgb_pkg::chan_add(color_green_r, in_data.code_byte);
      add_blue_r  <= rlgb_pkg::chan_add(color_blue_r, in_data.code_byte);
      prod_r      <= prod_full[rlgb_pkg::ADDR_W-1:0];
    end
  end

  // texel store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  rlgb_cursor u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (cur_ctrl),
    .map_width   (map_width_r),
    .rect_width  (rect_width_r),
    .rect_height (rect_height_r),
    .stat        (cur_stat)
  );

  assign out_valid           = out_valid_r;
  assign out_data.read_red   = out_red_r;
  assign out_data.read_green = out_green_r;
  assign out_data.read_blue  = out_blue_r;
  assign out_data.rect_done  = cur_stat.rows_zero;

endmodule

`default_nettype wire

[design/rlgb_checker.sv]
`default_nettype none

module rlgb_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input wire rlgb_pkg::in_t   in_data,
  input wire                  out_valid,
  input wire rlgb_pkg::out_t  out_data
);

  // reset leaves the block idle with no word pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // a word is never shown while an item is still at work
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // a texel write shows its result in the next cycle, with the block still idle
  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.kind == rlgb_pkg::KIND_WRITE |=> out_valid && !busy)
    else $error("texel write result missing");

  // a code word with no rectangle open is dropped at once
  a_idle_code: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.kind == rlgb_pkg::KIND_CODE && out_data.rect_done
    |=> out_valid && out_data.rect_done)
    else $error("idle code word handled wrongly");

  // a rectangle start makes the block busy, with no word shown, in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.kind == rlgb_pkg::KIND_START |=> busy && !out_valid)
    else $error("rectangle start not sequenced");

endmodule

bind rle_light_group_blender_top rlgb_checker u_checker (.*);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [11:0] addr;
    logic [11:0] base;
    logic [12:0] cols;
    logic [12:0] rows;
    logic [1:0]  phase;
    logic [7:0]  pending;
  } walk_t;

  typedef struct {
    rlgb_pkg::in_t  word;
    bit             fixed;
    rlgb_pkg::out_t want;
  } plan_row_t;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  rlgb_pkg::in_t  in_data;
  logic           out_valid;
  rlgb_pkg::out_t out_data;
  logic           cfg_we;
  logic [2:0]     cfg_index;
  logic [15:0]    cfg_data;

  // blender state as the bench sees it
  logic [23:0] shade_mem [0:4095];
  bit          ever_written [0:4095];
  logic [11:0] written_addrs [$];
  walk_t       cur;
  logic [15:0] color_r, color_g, color_b;
  logic [12:0] map_w, rect_w, rect_h;
  logic [11:0] rect_l, rect_t;
  logic [11:0] touched [0:1023];
  int          touched_n;

  rlgb_pkg::out_t due_replies [$];
  int          fail_count = 0;
  int          taken_words = 0;
  int          gap_rate = 0;
  int unsigned cycle_count = 0;

  rle_light_group_blender_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] gain(input logic [15:0] c, input logic [7:0] v);
    logic [23:0] p;
    p = c * v;
    return (p >= 24'h100000) ? 8'hFF : p[19:12];
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = a + b;
    return (s > 9'd255) ? 8'hFF : s[7:0];
  endfunction

  function automatic rlgb_pkg::in_t rand_word(input logic [1:0] kind);
    logic [63:0] bits;
    rlgb_pkg::in_t w;
    bits = {$urandom, $urandom};
    w = bits[$bits(rlgb_pkg::in_t)-1:0];
    w.kind = kind;
    return w;
  endfunction

  function automatic plan_row_t mk(input logic [1:0] kind, input logic [11:0] addr,
                                   input logic [23:0] rgb, input logic [7:0] code,
                                   input bit fixed, input logic [24:0] want);
    plan_row_t row;
    row.word = '0;
    row.word.kind = kind;
    row.word.texel_address = addr;
    {row.word.write_red, row.word.write_green, row.word.write_blue} = rgb;
    row.word.code_byte = code;
    row.fixed = fixed;
    row.want = want;
    return row;
  endfunction

  // light the texel under the cursor, then move the cursor on
  task automatic light_step;
    touched[touched_n] = cur.addr;
    touched_n++;
    if (cur.cols > 0) cur.cols--;
    if (cur.cols == 0) begin
      if (cur.rows > 0) cur.rows--;
      if (cur.rows != 0 && rect_w == 0) cur.rows = 0;
      if (cur.rows != 0) begin
        cur.base = cur.base + map_w[11:0];
        cur.addr = cur.base;
        cur.cols = rect_w;
      end
    end else begin
      cur.addr = cur.addr + 12'd1;
    end
  endtask

  task automatic take_code(input logic [7:0] code);
    int run;
    if (cur.rows != 0) begin
      if (cur.phase == rlgb_pkg::PHASE_COUNT) begin
        cur.pending = code;
        cur.phase = rlgb_pkg::PHASE_VALUE;
      end else if (cur.phase == rlgb_pkg::PHASE_PLAIN && code == rlgb_pkg::ESCAPE_CODE) begin
        cur.phase = rlgb_pkg::PHASE_COUNT;
      end else begin
        run = (cur.phase == rlgb_pkg::PHASE_VALUE) ? int'(cur.pending) : 0;
        light_step();
        while (run > 0 && cur.rows != 0) begin
          light_step();
          run--;
        end
        cur.pending = '0;
        cur.phase = rlgb_pkg::PHASE_PLAIN;
      end
    end
  endtask

  task automatic blend_predict(input rlgb_pkg::in_t w, output rlgb_pkg::out_t r);
    logic [23:0] t;
    logic [7:0]  ar, ag, ab;
    logic [31:0] origin;
    int i;
    r = '0;
    case (w.kind)
      rlgb_pkg::KIND_WRITE: begin
        shade_mem[w.texel_address] = {w.write_red, w.write_green, w.write_blue};
        if (!ever_written[w.texel_address]) begin
          ever_written[w.texel_address] = 1'b1;
          written_addrs.insert(written_addrs.size(), w.texel_address);
        end
      end
      rlgb_pkg::KIND_READ: begin
        {r.read_red, r.read_green, r.read_blue} = shade_mem[w.texel_address];
      end
      rlgb_pkg::KIND_START: begin
        origin = 32'(rect_t) * 32'(map_w) + 32'(rect_l);
        cur.phase = rlgb_pkg::PHASE_PLAIN;
        cur.pending = '0;
        cur.addr = origin[11:0];
        cur.base = origin[11:0];
        if (rect_w == 0 || rect_h == 0) begin
          cur.cols = '0;
          cur.rows = '0;
        end else begin
          cur.cols = rect_w;
          cur.rows = rect_h;
        end
      end
      default: begin
        touched_n = 0;
        take_code(w.code_byte);
        ar = gain(color_r, w.code_byte);
        ag = gain(color_g, w.code_byte);
        ab = gain(color_b, w.code_byte);
        for (i = 0; i < touched_n; i++) begin
          t = shade_mem[touched[i]];
          shade_mem[touched[i]] = {sat_add(t[23:16], ar), sat_add(t[15:8], ag),
                                   sat_add(t[7:0], ab)};
        end
      end
    endcase
    r.rect_done = (cur.rows == 13'd0);
  endtask

  task automatic send_word(input rlgb_pkg::in_t w, input bit fixed,
                           input rlgb_pkg::out_t fixed_want);
    rlgb_pkg::out_t want;
    if (gap_rate != 0 && $urandom_range(0, 99) < gap_rate) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_data <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    taken_words++;
    blend_predict(w, want);
    due_replies.insert(due_replies.size(), fixed ? fixed_want : want);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (due_replies.size() != 0 || busy);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      rlgb_pkg::REG_COLOR_RED:   color_r = val;
      rlgb_pkg::REG_COLOR_GREEN: color_g = val;
      rlgb_pkg::REG_COLOR_BLUE:  color_b = val;
      rlgb_pkg::REG_MAP_WIDTH:   map_w = val[12:0];
      rlgb_pkg::REG_RECT_LEFT:   rect_l = val[11:0];
      rlgb_pkg::REG_RECT_TOP:    rect_t = val[11:0];
      rlgb_pkg::REG_RECT_WIDTH:  rect_w = val[12:0];
      rlgb_pkg::REG_RECT_HEIGHT: rect_h = val[12:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] cr, input logic [15:0] cg,
                              input logic [15:0] cb, input logic [12:0] mw,
                              input logic [11:0] l, input logic [11:0] t,
                              input logic [12:0] w, input logic [12:0] h);
    set_reg(rlgb_pkg::REG_COLOR_RED, cr);
    set_reg(rlgb_pkg::REG_COLOR_GREEN, cg);
    set_reg(rlgb_pkg::REG_COLOR_BLUE, cb);
    set_reg(rlgb_pkg::REG_MAP_WIDTH, 16'(mw));
    set_reg(rlgb_pkg::REG_RECT_LEFT, 16'(l));
    set_reg(rlgb_pkg::REG_RECT_TOP, 16'(t));
    set_reg(rlgb_pkg::REG_RECT_WIDTH, 16'(w));
    set_reg(rlgb_pkg::REG_RECT_HEIGHT, 16'(h));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int goal);
    int pick, n, k, stop_at;
    logic [7:0]  seq [0:2];
    logic [11:0] need [$];
    walk_t keep;
    rlgb_pkg::in_t w;
    stop_at = taken_words + goal;
    while (taken_words < stop_at) begin
      pick = $urandom_range(0, 99);
      n = 0;
      if (cur.rows == 0 && pick >= 50) pick = 0;
      if (pick < 6) begin
        send_word(rand_word(rlgb_pkg::KIND_START), 1'b0, '0);
      end else if (pick < 20) begin
        send_word(rand_word(rlgb_pkg::KIND_WRITE), 1'b0, '0);
      end else if (pick < 32) begin
        w = rand_word(rlgb_pkg::KIND_READ);
        w.texel_address = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        send_word(w, 1'b0, '0);
      end else if (pick < 42) begin
        // stray or broken stream bytes
        n = $urandom_range(1, 2);
        for (k = 0; k < n; k++)
          seq[k] = ($urandom_range(0, 3) == 0) ? rlgb_pkg::ESCAPE_CODE
                                               : 8'($urandom_range(0, 255));
      end else if (pick < 60) begin
        n = 1;
        seq[0] = 8'($urandom_range(0, 254));
      end else begin
        n = 3;
        seq[0] = rlgb_pkg::ESCAPE_CODE;
        seq[1] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                             : 8'($urandom_range(0, 15));
        seq[2] = 8'($urandom_range(0, 255));
      end
      if (n != 0) begin
        // find the texels this sequence will light and give them contents first
        keep = cur;
        touched_n = 0;
        for (k = 0; k < n; k++) take_code(seq[k]);
        cur = keep;
        need.delete();
        for (k = 0; k < touched_n; k++) need.insert(need.size(), touched[k]);
        for (k = 0; k < need.size(); k++) begin
          if (!ever_written[need[k]]) begin
            w = rand_word(rlgb_pkg::KIND_WRITE);
            w.texel_address = need[k];
            send_word(w, 1'b0, '0);
          end
        end
        for (k = 0; k < n; k++) begin
          w = rand_word(rlgb_pkg::KIND_CODE);
          w.code_byte = seq[k];
          send_word(w, 1'b0, '0);
        end
      end
    end
  endtask

  task automatic note_bad(input string why, input rlgb_pkg::out_t want,
                          input rlgb_pkg::out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s: want r=%02h g=%02h b=%02h done=%0d, got r=%02h g=%02h b=%02h done=%0d",
               why, want.read_red, want.read_green, want.read_blue, want.rect_done,
               got.read_red, got.read_green, got.read_blue, got.rect_done);
  endtask

  always @(posedge clk) begin
    rlgb_pkg::out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (due_replies.size() == 0) begin
        note_bad("unexpected word", '0, out_data);
      end else begin
        want = due_replies.pop_front();
        if (out_data.read_red !== want.read_red || out_data.read_green !== want.read_green ||
            out_data.read_blue !== want.read_blue || out_data.rect_done !== want.rect_done)
          note_bad("mismatch", want, out_data);
      end
    end
  end

  initial begin
    plan_row_t plan [$];
    int ph, k;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur = '0;
    color_r = 16'd4096;
    color_g = 16'd4096;
    color_b = 16'd4096;
    map_w = 13'd64;
    rect_l = '0;
    rect_t = '0;
    rect_w = 13'd1;
    rect_h = 13'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // idle byte, extremes of the store, escapes, runs past the end, restart mid-escape
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'h80, 1'b1,
                                {24'h000000, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_WRITE, 12'd0,    24'hFF0080, 8'h00, 1'b1,
                                {24'h000000, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_WRITE, 12'd4095, 24'h00FF7F, 8'hFF, 1'b1,
                                {24'h000000, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_READ,  12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'hFF0080, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_READ,  12'd4095, 24'hFFFFFF, 8'h00, 1'b1,
                                {24'h00FF7F, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_START, 12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'h000000, 1'b0}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'h10, 1'b1,
                                {24'h000000, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_READ,  12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'hFF1090, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'h20, 1'b1,
                                {24'h000000, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_READ,  12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'hFF1090, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_START, 12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'h000000, 1'b0}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'hFF, 1'b1,
                                {24'h000000, 1'b0}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'h05, 1'b1,
                                {24'h000000, 1'b0}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'h000000, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_START, 12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'h000000, 1'b0}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'hFF, 1'b1,
                                {24'h000000, 1'b0}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'hFF, 1'b1,
                                {24'h000000, 1'b0}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'hFF, 1'b1,
                                {24'h000000, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_READ,  12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'hFFFFFF, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_WRITE, 12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'h000000, 1'b1}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_START, 12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'h000000, 1'b0}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'hFF, 1'b1,
                                {24'h000000, 1'b0}));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_START, 12'd0,    24'h000000, 8'h00, 1'b0,
                                '0));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_CODE,  12'd0,    24'h000000, 8'h01, 1'b0,
                                '0));
    plan.insert(plan.size(), mk(rlgb_pkg::KIND_READ,  12'd0,    24'h000000, 8'h00, 1'b1,
                                {24'h010101, 1'b1}));
    for (k = 0; k < plan.size(); k++) send_word(plan[k].word, plan[k].fixed, plan[k].want);

    for (ph = 0; ph < 11; ph++) begin
      drain();
      case (ph)
        0: program_regs(16'd4096, 16'd4096, 16'd4096, 13'd64, 12'd3, 12'd2, 13'd5, 13'd4);
        1: program_regs(16'd0, 16'hFFFF, 16'h1234, 13'd1, 12'd4095, 12'd4095,
                        13'd4096, 13'd4096);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd4096, 12'd0, 12'd4095,
                        13'd1, 13'd4096);
        3: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 13'd64, 12'd10, 12'd10,
                        13'd0, 13'd3);
        4: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 13'd100, 12'd5, 12'd5,
                        13'd4, 13'd0);
        default: program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                              ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 4096))
                                                          : 13'($urandom_range(1, 16)),
                              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                              13'($urandom_range(1, 8)), 13'($urandom_range(1, 6)));
      endcase
      gap_rate = (ph >= 9 || ph % 3 == 2) ? 0 : 25;
      run_phase(50);
    end

    drain();
    repeat (520) @(posedge clk);
    if (fail_count == 0 && due_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
